>>> hw/rtl/u8nv_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 name validator package
// Widths, code point limits and the sequence kind type of the validator; the byte
// channel interface takes its byte width from here.
// ----------------------------------------------------------------------------
package u8nv_pkg;

    // Width of one byte of the name string.
    localparam int unsigned BYTE_W = 8;

    // Width of a gathered code point.
    localparam int unsigned CP_W = 21;

    // Surrogate range (rejected in three-byte sequences).
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00E000;

    // First code point past the Unicode range (rejected in four-byte sequences).
    localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;

    // Kind of the open multi-byte sequence.
    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_kind_t;

endpackage

>>> hw/rtl/u8nv_stream_if.sv
// ----------------------------------------------------------------------------
// UTF-8 name validator channel interfaces
// Valid/ready channels for the incoming bytes and the outgoing verdicts.
// ----------------------------------------------------------------------------
interface u8nv_byte_if
    import u8nv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8nv_verdict_if;
    logic valid;
    logic ready;
    logic name_valid;

    modport source (output valid, output name_valid, input ready);
    modport sink   (input valid, input name_valid, output ready);
endinterface

>>> hw/rtl/utf8_name_validator_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 name validator
// Checks the bytes of one name string for well formed UTF-8 and gives one
// verdict per string, on the request that carries the final byte.
// ----------------------------------------------------------------------------
// Verdict path: the final byte's request is accepted into the input register,
//   then its verdict sits in the result register until taken.
// Throughput: one byte request per cycle, save while a final byte waits on a full
//   register; the state update is one compare and shift-or pass, input to state regs.
// Reset: rst_n clears the pipeline valid bits and the parsing state.
module utf8_name_validator_unit
    import u8nv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    u8nv_byte_if.sink             byte_stream,
    u8nv_verdict_if.source        verdict
);

    // Input register stage.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_advance;
    logic              in_accept;

    // Parsing state of the current string.
    logic [1:0]        pend_reg;
    logic [1:0]        pend_next;
    seq_kind_t         kind_reg;
    seq_kind_t         kind_next;
    logic [CP_W-1:0]   accum_reg;
    logic [CP_W-1:0]   accum_next;
    logic              err_reg;
    logic              err_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_verdict_reg;
    logic              out_verdict_next;

    // A byte without the final flag leaves no result, so it never waits on
    // the result register.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || verdict.ready);
    assign byte_stream.ready = !s1_valid_reg || s1_advance;
    assign in_accept = byte_stream.valid && byte_stream.ready;

    assign s1_valid_next = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    // Input stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= byte_stream.data_byte;
            s1_last_reg <= byte_stream.last_byte;
        end
    end

    // One parsing step per byte, then the verdict on the final byte.
    always_comb
    begin
        logic            is_cont;
        logic [1:0]      pend_dec;
        logic [CP_W-1:0] cont_bits;
        logic [CP_W-1:0] cp;

        is_cont          = (s1_byte_reg[7:6] == 2'b10);
        pend_dec         = pend_reg - 2'd1;
        cont_bits        = '0;
        cp               = '0;
        pend_next        = pend_reg;
        kind_next        = kind_reg;
        accum_next       = accum_reg;
        err_next         = err_reg;
        out_verdict_next = out_verdict_reg;

        if (s1_advance)
        begin
            if (pend_reg == 2'd0)
            begin
                // Single byte or lead byte.
                if (!s1_byte_reg[7])
                begin
                    pend_next = 2'd0;
                end
                else if (!s1_byte_reg[6])
                begin
                    err_next = 1'b1;
                end
                else if (!s1_byte_reg[5])
                begin
                    kind_next  = SEQ_TWO;
                    pend_next  = 2'd1;
                    accum_next = {10'b0, s1_byte_reg[4:0], 6'b0};
                end
                else if (!s1_byte_reg[4])
                begin
                    kind_next  = SEQ_THREE;
                    pend_next  = 2'd2;
                    accum_next = {5'b0, s1_byte_reg[3:0], 12'b0};
                end
                else
                begin
                    kind_next  = SEQ_FOUR;
                    pend_next  = 2'd3;
                    accum_next = {s1_byte_reg[2:0], 18'b0};
                    // Leads from 0xF8 up always exceed the code point range.
                    if (s1_byte_reg[3])
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            else if (!is_cont)
            begin
                // Broken sequence: drop it.
                err_next   = 1'b1;
                pend_next  = 2'd0;
                kind_next  = SEQ_NONE;
                accum_next = '0;
            end
            else
            begin
                // Continuation byte: place its six bits by position.
                case (pend_dec)
                    2'd2:    cont_bits = {3'b0, s1_byte_reg[5:0], 12'b0};
                    2'd1:    cont_bits = {9'b0, s1_byte_reg[5:0], 6'b0};
                    default: cont_bits = {15'b0, s1_byte_reg[5:0]};
                endcase
                cp         = accum_reg | cont_bits;
                pend_next  = pend_dec;
                accum_next = cp;
                if (pend_dec == 2'd0)
                begin
                    if (kind_reg == SEQ_THREE && cp >= SURR_LO && cp < SURR_HI)
                    begin
                        err_next = 1'b1;
                    end
                    if (kind_reg == SEQ_FOUR && cp >= CP_LIMIT)
                    begin
                        err_next = 1'b1;
                    end
                    kind_next  = SEQ_NONE;
                    accum_next = '0;
                end
            end

            // Final byte: a sequence left open rejects, then the string clears.
            if (s1_last_reg)
            begin
                out_verdict_next = !(err_next || (pend_next != 2'd0));
                pend_next        = 2'd0;
                kind_next        = SEQ_NONE;
                accum_next       = '0;
                err_next         = 1'b0;
            end
        end
    end

    // Parsing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 2'd0;
            kind_reg  <= SEQ_NONE;
            accum_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            kind_reg  <= kind_next;
            accum_reg <= accum_next;
            err_reg   <= err_next;
        end
    end

    // Result register: filled by a final byte, emptied when taken.
    assign out_valid_next = (s1_advance && s1_last_reg) ? 1'b1 :
                            (verdict.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_verdict_reg <= out_verdict_next;
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.name_valid = out_verdict_reg;

    // A new verdict only follows a final byte leaving the input stage.
    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("verdict appeared without a final byte");

    // Pending continuation count never exceeds what the open sequence needs.
    a_pend_in_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= kind_reg)
        else $error("pending count exceeds sequence kind");

    // With no sequence open, no code point bits are held.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd0) |-> (kind_reg == SEQ_NONE && accum_reg == '0))
        else $error("stale sequence state with nothing pending");

    // A stalled byte in the input stage holds its place.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_byte_reg)
                                          && $stable(s1_last_reg)))
        else $error("stalled input stage lost its byte");

endmodule
